@@ rtl/core/pdqs_pkg.sv @@
// ----------------------------------------------------------------------------
// pdqs_pkg
// Shared codes and controller/datapath interface types for the pair deque.
// ----------------------------------------------------------------------------
package pdqs_pkg;

    // operation codes carried on s_tuser
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    // result status codes carried on m_tuser
    localparam logic [2:0] ST_PUSH_EMPTY = 3'd0;
    localparam logic [2:0] ST_PUSHED     = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_REMOVED    = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_FOUND      = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // run the operation against front/count
        logic scan;   // walk the store one entry per cycle
        logic emit;   // move the pending result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_needed;  // search on a non-empty store
        logic scan_done;    // match found or last entry compared
        logic out_free;     // output register can take a result this cycle
    } stat_t;

endpackage

@@ rtl/core/pair_deque_with_search.sv @@
// With the master side ready, push, pop and unused opcodes pass from the taken input word
// through the execute and result states into the output register; a search also walks the
// store between those states and stops at a match or after the last entry is compared.
// One word at a time, the store walk reading one entry per cycle through its single read port.
// The next word is taken while a finished result still waits on the master side.
// Reset (aresetn low, synchronous): deque empty, front at slot 0, no result pending.
// ----------------------------------------------------------------------------
// pair_deque_with_search
// Bounded double-ended queue of value pairs with front-to-back linear search.
// ----------------------------------------------------------------------------
module pair_deque_with_search #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // first_value, second_value (low bits up), zero fill to bytes
    input  logic [((2*VALUE_BITS+7)/8)*8-1:0]         s_tdata,
    // opcode
    input  logic [2:0]                                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // position, zero fill to bytes
    output logic [(($clog2(DEPTH+1)+7)/8)*8-1:0]      m_tdata,
    // status
    output logic [2:0]                                m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = ((CW + 7) / 8) * 8;

    pdqs_pkg::cmd_t  cmd;
    pdqs_pkg::stat_t stat;
    logic [CW-1:0]   position;

    pdqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdqs_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_opcode    (s_tuser),
        .in_first     (s_tdata[VALUE_BITS-1:0]),
        .in_second    (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (m_tuser),
        .out_position (position)
    );

    assign m_tdata = OW'(position);

`ifndef SYNTHESIS
    // an accepted word is executed in the very next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> cmd.exec)
        else $error("accepted word not executed");

    // a result never overwrites one that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result emitted into a busy output register");

    // scan completion is only seen while scanning
    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.scan_done |-> cmd.scan)
        else $error("scan completion outside of a scan");

    // no new word is taken while the store is being walked
    a_no_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> !s_tready)
        else $error("input ready during a scan");
`endif

endmodule

@@ rtl/core/pdqs_ram.sv @@
// ----------------------------------------------------------------------------
// pdqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pdqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/pdqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdqs_ctrl
// Sequencer for the pair deque: accept, execute, scan, hand off result.
// ----------------------------------------------------------------------------
module pdqs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pdqs_pkg::stat_t stat,
    output pdqs_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.scan_needed ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                // wait for the output register to drain
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

@@ rtl/core/pdqs_datapath.sv @@
// ----------------------------------------------------------------------------
// pdqs_datapath
// Ring pointers, pair store, search compare and output register.
// ----------------------------------------------------------------------------
module pdqs_datapath #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pdqs_pkg::cmd_t                 cmd,
    output pdqs_pkg::stat_t                stat,
    input  logic [2:0]                     in_opcode,
    input  logic [VALUE_BITS-1:0]          in_first,
    input  logic [VALUE_BITS-1:0]          in_second,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [2:0]                     out_status,
    output logic [$clog2(DEPTH+1)-1:0]     out_position
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

    logic [2:0]            op_reg;
    logic [VALUE_BITS-1:0] first_reg;
    logic [VALUE_BITS-1:0] second_reg;
    logic [IW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         rd_idx_reg, rd_idx_next;
    logic [IW-1:0]         rd_slot_reg, rd_slot_next;
    logic [IW-1:0]         cmp_idx_reg;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic [CW-1:0]         res_pos_reg, res_pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            out_status_reg;
    logic [CW-1:0]         out_pos_reg;

    logic                      full;
    logic                      empty;
    logic                      is_push;
    logic [IW-1:0]             front_dec;
    logic [IW-1:0]             front_inc;
    logic [SW-1:0]             back_sum;
    logic [IW-1:0]             back_slot;
    logic [IW-1:0]             rd_slot_inc;
    logic                      issue;
    logic                      match;
    logic [CW-1:0]             cmp_pos;
    logic                      scan_done;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic [2*VALUE_BITS-1:0]   rd_data;

    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign is_push   = (op_reg == pdqs_pkg::OP_PUSH_FRONT) ||
                       (op_reg == pdqs_pkg::OP_PUSH_BACK);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;

    // back slot = (front + count) mod DEPTH, sum stays below twice DEPTH
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_slot = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);

    assign rd_slot_inc = (rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + 1'b1;

    assign match     = cmp_valid_reg && (rd_data == {second_reg, first_reg});
    assign cmp_pos   = CW'(cmp_idx_reg) + CW'(1);
    assign scan_done = cmp_valid_reg && (match || (cmp_pos == count_reg));
    assign issue     = cmd.scan && !scan_done && (rd_idx_reg < count_reg);

    assign wr_en   = cmd.exec && is_push && !full;
    assign wr_addr = (op_reg == pdqs_pkg::OP_PUSH_FRONT) ? front_dec : back_slot;

    assign stat.scan_needed = (op_reg == pdqs_pkg::OP_SEARCH) && !empty;
    assign stat.scan_done   = scan_done;
    assign stat.out_free    = !out_valid_reg || out_ready;

    pdqs_ram #(
        .WIDTH (2 * VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({second_reg, first_reg}),
        .rd_en   (issue),
        .rd_addr (rd_slot_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        front_next      = front_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rd_slot_next    = rd_slot_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;

        if (cmd.exec) begin
            rd_idx_next  = '0;
            rd_slot_next = front_reg;
            res_pos_next = '0;
            unique case (op_reg) inside
                pdqs_pkg::OP_PUSH_FRONT, pdqs_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        res_status_next = pdqs_pkg::ST_FULL;
                    end else begin
                        res_status_next = empty ? pdqs_pkg::ST_PUSH_EMPTY
                                                : pdqs_pkg::ST_PUSHED;
                        count_next      = count_reg + 1'b1;
                        if (op_reg == pdqs_pkg::OP_PUSH_FRONT) begin
                            front_next = front_dec;
                        end
                    end
                end
                pdqs_pkg::OP_POP_FRONT, pdqs_pkg::OP_POP_BACK: begin
                    if (empty) begin
                        res_status_next = pdqs_pkg::ST_EMPTY;
                    end else begin
                        res_status_next = pdqs_pkg::ST_REMOVED;
                        count_next      = count_reg - 1'b1;
                        if (op_reg == pdqs_pkg::OP_POP_FRONT) begin
                            front_next = front_inc;
                        end
                    end
                end
                pdqs_pkg::OP_SEARCH: begin
                    // non-empty case is settled by the scan
                    res_status_next = empty ? pdqs_pkg::ST_EMPTY : pdqs_pkg::ST_NOT_FOUND;
                end
                default: begin
                    res_status_next = pdqs_pkg::ST_NOT_FOUND;
                end
            endcase
        end

        if (issue) begin
            rd_idx_next  = rd_idx_reg + 1'b1;
            rd_slot_next = rd_slot_inc;
        end

        if (cmd.scan && scan_done) begin
            res_status_next = match ? pdqs_pkg::ST_FOUND : pdqs_pkg::ST_NOT_FOUND;
            res_pos_next    = match ? cmp_pos : '0;
        end
    end

    assign cmp_valid_next = issue;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_opcode;
            first_reg  <= in_first;
            second_reg <= in_second;
        end
        rd_idx_reg     <= rd_idx_next;
        rd_slot_reg    <= rd_slot_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        if (issue) begin
            cmp_idx_reg <= IW'(rd_idx_reg);
        end
        if (cmd.emit) begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_position = out_pos_reg;

endmodule
